### sv/dht_pkg.sv
// ----------------------------------------------------------------------------
// dht_pkg
// Shared widths, operation and status codes and state types for the
// double-hashing key table.
// ----------------------------------------------------------------------------
package dht_pkg;

	localparam int KEY_W    = 31;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int SLOT_W   = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NOKEY    = 3'd3;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

	typedef enum logic [1:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_PROBE
	} dht_state_t;

endpackage

### sv/dht_hash.sv
// ----------------------------------------------------------------------------
// dht_hash
// Pipelined hash unit: key mod table size (home slot) and the probe step
// (step modulus - key mod step modulus) reduced mod table size, both by
// reciprocal multiplication; done is registered after stages s1 to s4.
// ----------------------------------------------------------------------------
module dht_hash import dht_pkg::*; #(
	parameter int TABLE_SIZE   = 23,
	parameter int STEP_MODULUS = 11,
	localparam int IDX_W = $clog2(TABLE_SIZE)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [KEY_W-1:0] key,
	output logic             done,
	output logic [IDX_W-1:0] home,
	output logic [IDX_W-1:0] step
);

	localparam int SMR_W = $clog2(STEP_MODULUS);
	localparam int SM_W  = $clog2(STEP_MODULUS + 1);
	localparam int PK_W  = 2 * KEY_W + 1;
	localparam int PS_W  = 2 * SM_W + 1;
	localparam int SH_T  = KEY_W + IDX_W;
	localparam int SH_S  = KEY_W + SMR_W;
	localparam int SH_R  = SM_W + IDX_W;
	localparam longint unsigned T_L = 64'(TABLE_SIZE);
	localparam longint unsigned S_L = 64'(STEP_MODULUS);
	// reciprocals rounded up, exact quotients for any operand of the given width
	localparam longint unsigned MT_L = ((64'd1 << SH_T) + T_L - 64'd1) / T_L;
	localparam longint unsigned MS_L = ((64'd1 << SH_S) + S_L - 64'd1) / S_L;
	localparam longint unsigned MR_L = ((64'd1 << SH_R) + T_L - 64'd1) / T_L;
	localparam logic [KEY_W:0]   MT_C = (KEY_W + 1)'(MT_L);
	localparam logic [KEY_W:0]   MS_C = (KEY_W + 1)'(MS_L);
	localparam logic [SM_W:0]    MR_C = (SM_W + 1)'(MR_L);
	localparam logic [KEY_W-1:0] T_K  = KEY_W'(TABLE_SIZE);
	localparam logic [KEY_W-1:0] S_K  = KEY_W'(STEP_MODULUS);
	localparam logic [SM_W-1:0]  T_S  = SM_W'(TABLE_SIZE);
	localparam logic [SM_W-1:0]  SM_C = SM_W'(STEP_MODULUS);

	logic             v_s1, v_s2, v_s3, v_s4;
	logic [KEY_W-1:0] key_s1, key_s2;
	logic [KEY_W-1:0] qt_s2, qs_s2;
	logic [IDX_W-1:0] home_s3, home_s4;
	logic [SM_W-1:0]  sraw_s3, sraw_s4;
	logic [SM_W-1:0]  qr_s4;
	logic [IDX_W-1:0] home_q, step_q;
	logic             done_q;

	logic [PK_W-1:0]  prod_t, prod_s;
	logic [KEY_W-1:0] rem_t, rem_s;
	logic [PS_W-1:0]  prod_r;
	logic [SM_W-1:0]  rem_r;

	always_comb begin
		prod_t = PK_W'(key_s1) * PK_W'(MT_C);
		prod_s = PK_W'(key_s1) * PK_W'(MS_C);
		rem_t  = key_s2 - qt_s2 * T_K;
		rem_s  = key_s2 - qs_s2 * S_K;
		prod_r = PS_W'(sraw_s3) * PS_W'(MR_C);
		rem_r  = sraw_s4 - qr_s4 * T_S;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			v_s1   <= start;
			v_s2   <= v_s1;
			v_s3   <= v_s2;
			v_s4   <= v_s3;
			done_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (start) key_s1 <= key;
		key_s2  <= key_s1;
		qt_s2   <= KEY_W'(prod_t >> SH_T);
		qs_s2   <= KEY_W'(prod_s >> SH_S);
		home_s3 <= IDX_W'(rem_t);
		sraw_s3 <= SM_C - SM_W'(rem_s);
		home_s4 <= home_s3;
		sraw_s4 <= sraw_s3;
		qr_s4   <= SM_W'(prod_r >> SH_R);
		if (v_s4) begin
			home_q <= home_s4;
			step_q <= IDX_W'(rem_r);
		end
	end

	assign done = done_q;
	assign home = home_q;
	assign step = step_q;

endmodule

### sv/double_hash_table_top.sv
// ----------------------------------------------------------------------------
// double_hash_table_top
// Open-addressed key table with double hashing: insert, find or remove
// one key per item, one status and slot per item.
// ----------------------------------------------------------------------------
// sequence: the key is hashed in dht_hash, the home slot is read through the
//   registered table read, then one slot is checked per cycle, 1 to 23 slots
//   with defaults, and done follows the deciding check; an unused op code
//   answers the next cycle; one item at a time: busy drops as done rises,
//   and no new item is accepted while busy
// reset: busy stays high while the slot memory is cleared; done is never stalled
module double_hash_table_top import dht_pkg::*; #(
	parameter int TABLE_SIZE   = 23,
	parameter int STEP_MODULUS = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [OP_W-1:0]     op,
	input  logic [KEY_W-1:0]    key,
	output logic                done,
	output logic [STATUS_W-1:0] status,
	output logic [SLOT_W-1:0]   slot
);

	localparam int IDX_W  = $clog2(TABLE_SIZE);
	localparam int WORD_W = KEY_W + 1;
	localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_SIZE - 1);
	localparam logic [IDX_W:0]   T_C  = (IDX_W + 1)'(TABLE_SIZE);

	dht_state_t state_q, state_d;

	// entry: used bit on top, key below
	logic [WORD_W-1:0] mem [TABLE_SIZE];
	logic [WORD_W-1:0] rdata_s1;
	logic [IDX_W-1:0]  rd_pos_s1;
	logic              rd_vld_s1;

	logic [IDX_W-1:0]  clr_cnt_q;
	logic [IDX_W-1:0]  chk_cnt_q;
	logic [IDX_W-1:0]  pos_q;
	logic [OP_W-1:0]   op_q;
	logic [KEY_W-1:0]  key_q;

	logic                done_q;
	logic [STATUS_W-1:0] status_q;
	logic [SLOT_W-1:0]   slot_q;

	logic             accept, op_ok, h_start, h_done;
	logic [IDX_W-1:0] h_home, h_step;
	logic [IDX_W:0]   pos_sum;
	logic [IDX_W-1:0] pos_next;

	logic                mem_we;
	logic [IDX_W-1:0]    mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic                fin;
	logic [STATUS_W-1:0] res_status;
	logic [IDX_W-1:0]    res_slot;
	logic                e_used, e_match;

	assign accept  = start && (state_q == S_IDLE);
	assign op_ok   = (op == OP_INSERT) || (op == OP_FIND) || (op == OP_REMOVE);
	assign h_start = accept && op_ok;

	dht_hash #(
		.TABLE_SIZE  (TABLE_SIZE),
		.STEP_MODULUS(STEP_MODULUS)
	) u_hash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (h_start),
		.key   (key),
		.done  (h_done),
		.home  (h_home),
		.step  (h_step)
	);

	always_comb begin
		pos_sum  = {1'b0, pos_q} + {1'b0, h_step};
		pos_next = (pos_sum >= T_C) ? IDX_W'(pos_sum - T_C) : IDX_W'(pos_sum);
	end

	assign e_used  = rdata_s1[WORD_W-1];
	assign e_match = (rdata_s1[KEY_W-1:0] == key_q);

	// memory clearing, and the probe check on the entry read last cycle
	always_comb begin
		mem_we     = 1'b0;
		mem_waddr  = clr_cnt_q;
		mem_wdata  = '0;
		fin        = 1'b0;
		res_status = ST_NOKEY;
		res_slot   = '0;
		case (state_q)
			S_CLEAR: begin
				mem_we = 1'b1;
			end
			S_PROBE: begin
				if (rd_vld_s1) begin
					if (op_q == OP_INSERT) begin
						if (!e_used) begin
							mem_we     = 1'b1;
							mem_waddr  = rd_pos_s1;
							mem_wdata  = {1'b1, key_q};
							fin        = 1'b1;
							res_status = ST_INSERTED;
							res_slot   = rd_pos_s1;
						end
					end else begin
						if (!e_used) begin
							fin = 1'b1;
						end else if (e_match) begin
							fin      = 1'b1;
							res_slot = rd_pos_s1;
							if (op_q == OP_REMOVE) begin
								mem_we     = 1'b1;
								mem_waddr  = rd_pos_s1;
								res_status = ST_REMOVED;
							end else begin
								res_status = ST_FOUND;
							end
						end
					end
					// full lap without a decision
					if (!fin && chk_cnt_q == LAST) begin
						fin        = 1'b1;
						res_status = (op_q == OP_INSERT) ? ST_FULL : ST_NOKEY;
					end
				end
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				if (clr_cnt_q == LAST) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (h_start) state_d = S_HASH;
			end
			S_HASH: begin
				if (h_done) state_d = S_PROBE;
			end
			S_PROBE: begin
				if (fin) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			clr_cnt_q <= '0;
			chk_cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == S_PROBE) && !fin;
			done_q    <= fin || (accept && !op_ok);
			if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (state_q == S_HASH) chk_cnt_q <= '0;
			else if (state_q == S_PROBE && rd_vld_s1) chk_cnt_q <= chk_cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op;
			key_q <= key;
		end
		if (state_q == S_HASH) pos_q <= h_home;
		else if (state_q == S_PROBE) pos_q <= pos_next;
		if (fin) begin
			status_q <= res_status;
			slot_q   <= SLOT_W'(res_slot);
		end else if (accept && !op_ok) begin
			status_q <= ST_NOKEY;
			slot_q   <= '0;
		end
	end

	// slot memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_waddr] <= mem_wdata;
		rdata_s1  <= mem[pos_q];
		rd_pos_s1 <= pos_q;
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign status = status_q;
	assign slot   = slot_q;

endmodule

### sv/dht_checker.sv
// ----------------------------------------------------------------------------
// dht_checker
// Port-level checks on the double-hashing key table, bound to the top level.
// ----------------------------------------------------------------------------
module dht_checker import dht_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic [OP_W-1:0]     op,
	input logic                done,
	input logic [STATUS_W-1:0] status,
	input logic [SLOT_W-1:0]   slot
);

	// an accepted real operation raises busy
	a_busy_after_op: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (op == OP_INSERT || op == OP_FIND || op == OP_REMOVE)
		|=> busy)
		else $error("busy not raised after an accepted operation");

	// no result appears out of an idle cycle with nothing accepted
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !done)
		else $error("result without an item");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_INSERTED || status == ST_FOUND || status == ST_REMOVED
			|| status == ST_NOKEY || status == ST_FULL))
		else $error("status code out of range");

	a_miss_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_NOKEY || status == ST_FULL) |-> slot == '0)
		else $error("slot not zero on a miss");

	// a result ends the busy period of its item
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while still busy");

endmodule

bind double_hash_table_top dht_checker u_dht_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.op    (op),
	.done  (done),
	.status(status),
	.slot  (slot)
);
